>>> hw/rtl/ovlt_pkg.sv
// Shared codes and controller/datapath interface types for the ordered value list table.
`default_nettype none

package ovlt_pkg;

    // Request kinds
    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_FIND    = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;
    localparam logic [1:0] REQ_REPLACE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Write data sources
    localparam logic [1:0] WR_VALUE = 2'd0;
    localparam logic [1:0] WR_NEW   = 2'd1;
    localparam logic [1:0] WR_RD    = 2'd2;

    typedef struct packed {
        logic       capture;     // latch the request payload
        logic       rd_en;       // read the table, data valid next cycle
        logic       rd_next;     // read at idx+1 instead of idx
        logic       wr_en;       // write the table
        logic [1:0] wr_src;      // write data source
        logic       wr_at_tail;  // write at the fill count instead of idx
        logic       idx_clr;
        logic       idx_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;    // load the result register
        logic [1:0] out_status;
    } ovlt_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;    // latched request kind
        logic       match;       // read data equals the latched value
        logic       last;        // idx is the last stored entry
        logic       full;
        logic       empty;
        logic       out_busy;    // result register holds an untaken result
    } ovlt_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ovlt_datapath.sv
// Datapath: value table memory, scan index, fill count and result register.
`default_nettype none

module ovlt_datapath #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  ovlt_pkg::ovlt_cmd_t  cmd,
    output ovlt_pkg::ovlt_stat_t       stat,
    input  wire  [1:0]               req_type,
    input  wire  signed [31:0]       value,
    input  wire  signed [31:0]       new_value,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         entry_count
);
    import ovlt_pkg::*;

    logic [31:0]      mem [CAPACITY];
    logic [31:0]      rd_reg;
    logic [1:0]       type_reg;
    logic [31:0]      value_reg;
    logic [31:0]      new_value_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic [IDX_W-1:0] idx_plus1;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;

    assign idx_plus1 = idx_reg + 1'b1;
    assign rd_addr   = cmd.rd_next ? idx_plus1 : idx_reg;
    assign wr_addr   = cmd.wr_at_tail ? cnt_reg[IDX_W-1:0] : idx_reg;

    always_comb
    begin
        unique case (cmd.wr_src)
            WR_VALUE: wr_data = value_reg;
            WR_NEW:   wr_data = new_value_reg;
            WR_RD:    wr_data = rd_reg;
            default:  wr_data = rd_reg;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_plus1;

        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
        else if (cmd.cnt_dec)
            cnt_next = cnt_reg - 1'b1;

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg      <= req_type;
            value_reg     <= value;
            new_value_reg <= new_value;
        end
        if (cmd.out_load)
        begin
            status_reg  <= cmd.out_status;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign stat.req_type = type_reg;
    assign stat.match    = (rd_reg == value_reg);
    assign stat.last     = ((CNT_W'(idx_reg) + 1'b1) == cnt_reg);
    assign stat.full     = (cnt_reg == CNT_W'(CAPACITY));
    assign stat.empty    = (cnt_reg == '0);
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = out_cnt_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ovlt_ctrl.sv
// Controller: sequences add, scan, shift-on-remove and result hand-off.
`default_nettype none

module ovlt_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  ovlt_pkg::ovlt_stat_t stat,
    output ovlt_pkg::ovlt_cmd_t        cmd
);
    import ovlt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_SHCHK = 3'd4;
    localparam logic [2:0] S_SHWR  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.out_status = st_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.req_type == REQ_ADD)
                begin
                    if (stat.full)
                        st_next = ST_FULL;
                    else
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_src     = WR_VALUE;
                        cmd.wr_at_tail = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                        st_next        = ST_OK;
                    end
                    state_next = S_RESP;
                end
                else if (stat.empty)
                begin
                    st_next    = ST_MISSING;
                    state_next = S_RESP;
                end
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    st_next = ST_OK;
                    if (stat.req_type == REQ_REMOVE)
                        state_next = S_SHCHK;
                    else
                    begin
                        if (stat.req_type == REQ_REPLACE)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_src = WR_NEW;
                        end
                        state_next = S_RESP;
                    end
                end
                else if (stat.last)
                begin
                    st_next    = ST_MISSING;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_SHCHK:
            begin
                if (stat.last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_src  = WR_RD;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHCHK;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ordered_value_list_table.sv
// Top level of the ordered value list table: controller plus table datapath.
// An add, or any request on an empty table, goes from S_START straight to S_RESP; find
// and replace repeat S_READ and S_CMP per entry scanned; remove then shifts via S_SHCHK/S_SHWR.
// Requests are handled one at a time, each entry read through the single registered read
// port; a result not yet taken holds the next result back.
// Reset clears the fill count and control; the table memory is not cleared.
`default_nettype none

module ordered_value_list_table #(
    parameter int CAPACITY = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // request transaction
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [1:0]                         req_type,
    input  wire  signed [31:0]                 value,
    input  wire  signed [31:0]                 new_value,
    // result transaction
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [1:0]                         status,
    output logic [$clog2(CAPACITY + 1)-1:0]    entry_count
);
    import ovlt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Command and status buses between the sequencer and the table
    ovlt_cmd_t  cmd;
    ovlt_stat_t stat;

    // Sequencer: accept a transaction only when idle, walk the table, then
    // hold the result until the output register is free.
    ovlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table memory, scan index, fill count and the result register. The
    // result register lets the next request in while a result waits.
    ovlt_datapath #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .value       (value),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

>>> sim/ordered_value_list_table_tb.sv
// Self-checking regression bench for the ordered value list table.
`default_nettype none

module ordered_value_list_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ovlt_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1750;
    localparam int QUIET_TAIL   = 200;        // last requests run with no idling
    localparam int SETTLE       = 4 * CAPACITY + 8;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int POOL_SIZE    = 8;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic signed [31:0] new_value;
    } list_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } list_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Drive every input to a known value from time zero.
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type  = REQ_FIND;
    logic signed [31:0]      value     = '0;
    logic signed [31:0]      new_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              status;
    logic [CNT_W-1:0]        entry_count;

    // Requests waiting to be driven, results still owed by the block, and the
    // bench's own copy of the stored list (head at index 0).
    list_req_t          queued_requests[$];
    list_res_t          due_results[$];
    logic signed [31:0] shadow_list[$];

    logic [31:0] value_pool[POOL_SIZE];
    logic        stimulus_loaded = 1'b0;
    int          errors          = 0;
    int          cycles          = 0;

    ordered_value_list_table #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it owes.
    // Matching looks for the first hit from the head, so duplicates behind it
    // are left alone by remove and replace.
    function automatic list_res_t apply_to_shadow_list(list_req_t req);
        list_res_t res;
        int        hit;
        res.status = ST_OK;
        hit        = -1;
        for (int i = 0; i < shadow_list.size(); i++)
        begin
            if (hit < 0 && shadow_list[i] == req.value)
                hit = i;
        end
        case (req.kind)
            REQ_ADD:
            begin
                if (shadow_list.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                    shadow_list.push_back(req.value);
            end
            REQ_FIND:
            begin
                if (hit < 0)
                    res.status = ST_MISSING;
            end
            REQ_REMOVE:
            begin
                // delete closes the gap, keeping insertion order
                if (hit < 0)
                    res.status = ST_MISSING;
                else
                    shadow_list.delete(hit);
            end
            default:
            begin
                if (hit < 0)
                    res.status = ST_MISSING;
                else
                    shadow_list[hit] = req.new_value;
            end
        endcase
        res.count = CNT_W'(shadow_list.size());
        return res;
    endfunction

    // No idling once the last stretch of requests is reached.
    function automatic logic quiet_tail();
        return stimulus_loaded && queued_requests.size() < QUIET_TAIL;
    endfunction

    // Mostly values from a small pool so that find, remove and replace hit,
    // plus the extremes and fully random words so that every bit toggles.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
    endfunction

    task automatic queue_req(input logic [1:0] kind, input logic [31:0] v,
                             input logic [31:0] nv);
        list_req_t req;
        req.kind      = kind;
        req.value     = v;
        req.new_value = nv;
        queued_requests.push_back(req);
    endtask

    // Request driver: predict on every accepted transaction, then either idle
    // for a burst or launch the next queued request. valid gets one
    // assignment per edge so a back-to-back launch keeps it high.
    int        in_gap  = 0;
    int        in_calm = 0;
    logic      in_next;
    list_req_t launch;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            in_next = in_valid;
            if (in_valid && in_ready)
            begin
                due_results.push_back(apply_to_shadow_list({req_type, value, new_value}));
                in_next = 1'b0;
            end
            if (in_calm > 0)
                in_calm--;
            else if ($urandom_range(0, 199) == 0)
                in_calm = $urandom_range(50, 200);
            if (!in_next)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end
                else if (queued_requests.size() > 0)
                begin
                    if (!quiet_tail() && in_calm == 0 && $urandom_range(0, 5) == 0)
                    begin
                        // this edge is the first idle cycle of the burst
                        in_gap = $urandom_range(1, 17) - 1;
                    end
                    else
                    begin
                        launch    = queued_requests.pop_front();
                        req_type  <= launch.kind;
                        value     <= launch.value;
                        new_value <= launch.new_value;
                        in_next   = 1'b1;
                    end
                end
            end
            in_valid <= in_next;
        end
    end

    // Result monitor: check each accepted result against the oldest one owed,
    // then decide whether to stall the next cycle.
    int        out_gap  = 0;
    int        out_calm = 0;
    logic      out_next;
    list_res_t owed;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                             $time, status, entry_count);
                    errors++;
                end
                else
                begin
                    owed = due_results.pop_front();
                    if (status !== owed.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, owed.status, status);
                        errors++;
                    end
                    if (entry_count !== owed.count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                                 $time, owed.count, entry_count);
                        errors++;
                    end
                end
            end
            if (out_calm > 0)
                out_calm--;
            else if ($urandom_range(0, 199) == 0)
                out_calm = $urandom_range(50, 200);
            out_next = 1'b1;
            if (out_gap > 0)
            begin
                out_gap--;
                out_next = 1'b0;
            end
            else if (!quiet_tail() && out_calm == 0 && $urandom_range(0, 5) == 0)
            begin
                out_gap  = $urandom_range(1, 17) - 1;
                out_next = 1'b0;
            end
            out_ready <= out_next;
        end
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("ordered_value_list_table regression: fail");
            $finish;
        end
    end

    initial
    begin
        int roll;
        int bias;
        logic [1:0] kind;

        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Start on the empty table: nothing can match.
        queue_req(REQ_FIND,    32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_REMOVE,  32'h0000_0005, 32'h0000_0000);
        queue_req(REQ_REPLACE, 32'h0000_0005, 32'h0000_0006);
        // Extremes, with new_value set to show it is ignored outside replace,
        // and a duplicate of minus one behind the first.
        queue_req(REQ_ADD,     32'h8000_0000, 32'h7fff_ffff);
        queue_req(REQ_ADD,     32'h7fff_ffff, 32'h8000_0000);
        queue_req(REQ_ADD,     32'hffff_ffff, 32'hffff_ffff);
        queue_req(REQ_ADD,     32'h0000_0000, 32'hffff_ffff);
        queue_req(REQ_ADD,     32'hffff_ffff, 32'h0000_0000);
        queue_req(REQ_FIND,    32'h8000_0000, 32'h0000_0000);
        queue_req(REQ_FIND,    32'h7fff_fffe, 32'h7fff_ffff);
        // Only the first minus one goes, then the second is replaced.
        queue_req(REQ_REMOVE,  32'hffff_ffff, 32'h0000_0000);
        queue_req(REQ_REPLACE, 32'hffff_ffff, 32'h0000_002a);
        queue_req(REQ_FIND,    32'hffff_ffff, 32'h0000_0000);
        // Fill to capacity, then one add too many.
        for (int i = 0; i < CAPACITY - 4; i++)
            queue_req(REQ_ADD, $urandom(), $urandom());
        queue_req(REQ_ADD,     32'h1234_5678, 32'h0000_0000);

        // Hold further stimulus until every owed result has come back.
        while (queued_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);

        // Random part, in segments that lean toward filling, draining or a
        // mix so the count sweeps between empty and full.
        bias = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                bias = $urandom_range(0, 2);
                value_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
            end
            roll = $urandom_range(0, 99);
            case (bias)
                0: kind = roll < 55 ? REQ_ADD : roll < 70 ? REQ_FIND :
                          roll < 85 ? REQ_REMOVE : REQ_REPLACE;
                1: kind = roll < 15 ? REQ_ADD : roll < 35 ? REQ_FIND :
                          roll < 80 ? REQ_REMOVE : REQ_REPLACE;
                default: kind = roll < 30 ? REQ_ADD : roll < 55 ? REQ_FIND :
                                roll < 80 ? REQ_REMOVE : REQ_REPLACE;
            endcase
            queue_req(kind, pick_value(),
                      $urandom_range(0, 2) == 0 ? $urandom() : pick_value());
        end
        stimulus_loaded = 1'b1;

        // Drain, then give the block time to show any stray result.
        while (queued_requests.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && due_results.size() == 0)
            $display("ordered_value_list_table regression: pass");
        else
            $display("ordered_value_list_table regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
